FILE: hdl/mpd_pkg.sv
// ----------------------------------------------------------------------------
// mpd_pkg
// Shared types, codes and the property type table of the property decoder.
// ----------------------------------------------------------------------------
package mpd_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef enum logic [2:0] {
    KIND_INT    = 3'd0,
    KIND_HEADER = 3'd1,
    KIND_BYTE   = 3'd2,
    KIND_DONE   = 3'd3,
    KIND_ERROR  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_DUPLICATE = 3'd1,
    ERR_UNKNOWN   = 3'd2,
    ERR_TRUNCATED = 3'd3,
    ERR_VARINT    = 3'd4
  } err_e;

  typedef enum logic [2:0] {
    T_BYTE = 3'd0,
    T_TWO  = 3'd1,
    T_FOUR = 3'd2,
    T_VAR  = 3'd3,
    T_STR  = 3'd4,
    T_PAIR = 3'd5,
    T_BIN  = 3'd6,
    T_NONE = 3'd7
  } ptype_e;

  localparam logic [7:0] UserProp = 8'h26;

  // One result item.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  prop_id;
    logic        part_index;
    logic [31:0] int_value;
    logic [7:0]  payload_byte;
    logic        part_end;
    err_e        error_code;
    logic        last_result;
  } result_t;

  // What the front end hands to the back end for one input byte.
  typedef struct packed {
    logic    has_prop;
    result_t prop;
    logic    has_done;
    result_t done;
  } entry_t;

  function automatic ptype_e type_of_id(input logic [7:0] b);
    ptype_e t;
    t = T_NONE;
    case (b)
      8'h01, 8'h17, 8'h19, 8'h24, 8'h25, 8'h28, 8'h29, 8'h2A: t = T_BYTE;
      8'h13, 8'h21, 8'h22, 8'h23:                            t = T_TWO;
      8'h02, 8'h11, 8'h18, 8'h27:                            t = T_FOUR;
      8'h0B:                                                 t = T_VAR;
      8'h03, 8'h08, 8'h12, 8'h15, 8'h1A, 8'h1C, 8'h1F:       t = T_STR;
      8'h26:                                                 t = T_PAIR;
      8'h09, 8'h16:                                          t = T_BIN;
      default:                                               t = T_NONE;
    endcase
    return t;
  endfunction

endpackage

FILE: hdl/mpd_front.sv
// ----------------------------------------------------------------------------
// mpd_front
// Parses one section byte per cycle while take_i is high and forms up to two result items for it.
// ----------------------------------------------------------------------------
module mpd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [7:0]      section_byte_i,
  input  logic            section_last_i,
  input  logic            take_i,
  output mpd_pkg::entry_t entry_o
);
  import mpd_pkg::*;

  localparam logic [3:0] PH_ID   = 4'd0;
  localparam logic [3:0] PH_INT  = 4'd1;
  localparam logic [3:0] PH_VAR  = 4'd2;
  localparam logic [3:0] PH_LHI  = 4'd3;
  localparam logic [3:0] PH_LLO  = 4'd4;
  localparam logic [3:0] PH_DATA = 4'd5;

  logic [3:0]  phase_q, phase_d;
  logic [7:0]  id_q, id_d;
  ptype_e      type_q, type_d;
  logic [15:0] left_q, left_d;
  logic [31:0] acc_q, acc_d;
  logic [1:0]  shift_q, shift_d;
  logic        second_q, second_d;
  logic [63:0] seen_q, seen_d;
  logic        hold_q, hold_d;

  result_t r;
  logic    has_r;
  ptype_e  t;
  logic [15:0] left_m1;
  logic [31:0] vpart;

  always_comb begin
    phase_d = phase_q; id_d = id_q; type_d = type_q; left_d = left_q;
    acc_d = acc_q; shift_d = shift_q; second_d = second_q;
    seen_d = seen_q; hold_d = hold_q;
    r = '0;
    has_r = 1'b0;
    t = (section_byte_i[7:6] == 2'b00) ? type_of_id(section_byte_i) : T_NONE;
    left_m1 = left_q - 16'd1;
    vpart = 32'(section_byte_i[6:0]) << (7 * shift_q);
    r.prop_id = id_q;
    r.part_index = second_q;
    if (!hold_q) begin
      unique case (phase_q)
        PH_ID: begin
          id_d = section_byte_i;
          r.prop_id = section_byte_i;
          if (t == T_NONE) begin
            has_r = 1'b1; r.kind = KIND_ERROR; r.error_code = ERR_UNKNOWN;
            r.part_index = 1'b0; hold_d = 1'b1;
          end else if (section_byte_i != UserProp && seen_q[section_byte_i[5:0]]) begin
            has_r = 1'b1; r.kind = KIND_ERROR; r.error_code = ERR_DUPLICATE;
            r.part_index = 1'b0; hold_d = 1'b1;
          end else begin
            seen_d[section_byte_i[5:0]] = 1'b1;
            type_d = t; acc_d = '0; shift_d = '0; second_d = 1'b0;
            case (t)
              T_BYTE: begin left_d = 16'd1; phase_d = PH_INT; end
              T_TWO:  begin left_d = 16'd2; phase_d = PH_INT; end
              T_FOUR: begin left_d = 16'd4; phase_d = PH_INT; end
              T_VAR:  phase_d = PH_VAR;
              default: phase_d = PH_LHI;
            endcase
          end
        end
        PH_INT: begin
          acc_d = {acc_q[23:0], section_byte_i};
          left_d = left_m1;
          if (left_m1 == '0) begin
            has_r = 1'b1; r.kind = KIND_INT; r.int_value = acc_d;
            r.part_index = 1'b0; phase_d = PH_ID;
          end
        end
        PH_VAR: begin
          acc_d = acc_q | vpart;
          if (section_byte_i[7]) begin
            if (shift_q == 2'd3) begin
              has_r = 1'b1; r.kind = KIND_ERROR; r.error_code = ERR_VARINT;
              r.part_index = 1'b0; hold_d = 1'b1;
            end else begin
              shift_d = shift_q + 2'd1;
            end
          end else begin
            has_r = 1'b1; r.kind = KIND_INT; r.int_value = acc_d;
            r.part_index = 1'b0; phase_d = PH_ID;
          end
        end
        PH_LHI: begin
          acc_d = {16'd0, section_byte_i, 8'd0};
          phase_d = PH_LLO;
        end
        PH_LLO: begin
          acc_d = acc_q | 32'(section_byte_i);
          has_r = 1'b1; r.kind = KIND_HEADER; r.int_value = acc_d;
          left_d = acc_d[15:0];
          if (acc_d[15:0] == '0) begin
            if (type_q == T_PAIR && !second_q) begin
              second_d = 1'b1; phase_d = PH_LHI;
            end else phase_d = PH_ID;
          end else phase_d = PH_DATA;
        end
        PH_DATA: begin
          left_d = left_m1;
          has_r = 1'b1; r.kind = KIND_BYTE; r.payload_byte = section_byte_i;
          r.part_end = (left_m1 == '0);
          if (left_m1 == '0) begin
            if (type_q == T_PAIR && !second_q) begin
              second_d = 1'b1; phase_d = PH_LHI;
            end else phase_d = PH_ID;
          end
        end
        default: phase_d = PH_ID;
      endcase
    end
    r.last_result = !section_last_i;
    entry_o = '0;
    entry_o.has_prop = has_r;
    entry_o.prop = r;
    entry_o.has_done = section_last_i;
    entry_o.done.kind = KIND_DONE;
    entry_o.done.error_code = (!hold_d && phase_d != PH_ID) ? ERR_TRUNCATED : ERR_NONE;
    entry_o.done.last_result = 1'b1;
    if (section_last_i) begin
      phase_d = PH_ID; id_d = '0; type_d = T_BYTE; left_d = '0; acc_d = '0;
      shift_d = '0; second_d = 1'b0; seen_d = '0; hold_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ID; id_q <= '0; type_q <= T_BYTE; left_q <= '0;
      acc_q <= '0; shift_q <= '0; second_q <= 1'b0; seen_q <= '0; hold_q <= 1'b0;
    end else if (in_valid_i && take_i) begin
      phase_q <= phase_d; id_q <= id_d; type_q <= type_d; left_q <= left_d;
      acc_q <= acc_d; shift_q <= shift_d; second_q <= second_d;
      seen_q <= seen_d; hold_q <= hold_d;
    end
  end

  // The last byte of a section always leaves the parser ready for a fresh identifier.
  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && take_i && section_last_i |=> phase_q == PH_ID && !hold_q && seen_q == '0)
    else $error("section end did not reset parser");
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q |-> !entry_o.has_prop)
    else $error("result while error hold");
  a_seen_user: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q[0]) else $error("id zero marked seen");
endmodule

FILE: hdl/mpd_back.sv
// ----------------------------------------------------------------------------
// mpd_back
// Entry queue and result sequencer: sends up to two result items per entry.
// ----------------------------------------------------------------------------
module mpd_back #(
  parameter int unsigned Depth = mpd_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mpd_pkg::entry_t  entry_i,
  output logic             full_o,
  output logic             out_valid_o,
  output mpd_pkg::result_t result_o,
  input  logic             out_ready_i
);
  import mpd_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  entry_t         mem_q [Depth];
  logic [AW-1:0]  wp_q, rp_q;
  logic [AW:0]    cnt_q;
  logic           sub_q;   // 1 once the property result of the head went out
  entry_t         head;
  logic           pop, send;

  assign head = mem_q[rp_q];
  assign full_o = (cnt_q == (AW+1)'(Depth));
  // Entries with no result never reach the queue, so the head always has one.
  assign out_valid_o = (cnt_q != '0);
  assign result_o = (head.has_prop && !sub_q) ? head.prop : head.done;
  assign send = out_valid_o && out_ready_i;
  assign pop = send && (sub_q || !head.has_prop || !head.has_done);

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0; sub_q <= 1'b0;
    end else begin
      if (push_i) wp_q <= inc(wp_q);
      if (pop) rp_q <= inc(rp_q);
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop);
      if (pop) sub_q <= 1'b0;
      else if (send) sub_q <= 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue overflow");
  a_sub_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q |-> out_valid_o && head.has_prop && head.has_done)
    else $error("second result without pair");
  a_head_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> head.has_prop || head.has_done) else $error("empty head");
endmodule

FILE: hdl/mqtt5_property_decoder.sv
// ----------------------------------------------------------------------------
// mqtt5_property_decoder
// MQTT 5 property section decoder, one section byte per item.
// ----------------------------------------------------------------------------
// Takes one byte per cycle whenever the result queue has room; each byte
// gives zero, one or two result items. The parser works in the cycle of
// acceptance and writes its results into a queue of Depth entries, from which
// results leave at one per cycle while out_ready_i holds; a byte causing two
// results (a property result and the section end) sends them in turn.
module mqtt5_property_decoder #(
  parameter int unsigned Depth = mpd_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  section_byte_i,
  input  logic        section_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_kind_o,
  output logic [7:0]  prop_id_o,
  output logic        part_index_o,
  output logic [31:0] int_value_o,
  output logic [7:0]  payload_byte_o,
  output logic        part_end_o,
  output logic [2:0]  error_code_o,
  output logic        last_result_o
);
  import mpd_pkg::*;

  entry_t  entry;
  result_t res;
  logic    full;

  assign in_ready_o = !full;

  mpd_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .section_byte_i, .section_last_i,
    .take_i(in_ready_o), .entry_o(entry)
  );

  mpd_back #(.Depth(Depth)) u_back (
    .clk_i, .rst_ni,
    .push_i(in_valid_i && in_ready_o && (entry.has_prop || entry.has_done)),
    .entry_i(entry), .full_o(full), .out_valid_o,
    .result_o(res), .out_ready_i
  );

  assign result_kind_o  = res.kind;
  assign prop_id_o      = res.prop_id;
  assign part_index_o   = res.part_index;
  assign int_value_o    = res.int_value;
  assign payload_byte_o = res.payload_byte;
  assign part_end_o     = res.part_end;
  assign error_code_o   = res.error_code;
  assign last_result_o  = res.last_result;
endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the MQTT 5 property decoder against a built-in predictor of its
// results, with directed sections first and random sections after.
// ----------------------------------------------------------------------------
module tb;
  import mpd_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  sec_byte;
  logic        sec_last;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  res_kind;
  logic [7:0]  res_id;
  logic        res_part;
  logic [31:0] res_int;
  logic [7:0]  res_pb;
  logic        res_pend;
  logic [2:0]  res_err;
  logic        res_last;

  mqtt5_property_decoder u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .section_byte_i(sec_byte), .section_last_i(sec_last),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .result_kind_o(res_kind), .prop_id_o(res_id), .part_index_o(res_part),
    .int_value_o(res_int), .payload_byte_o(res_pb), .part_end_o(res_pend),
    .error_code_o(res_err), .last_result_o(res_last)
  );

  typedef enum logic [2:0] {
    P_ID, P_INT, P_VAR, P_LHI, P_LLO, P_DATA
  } phase_e;

  // Predictor state.
  phase_e      ph;
  logic [7:0]  cur_id;
  ptype_e      cur_type;
  logic [15:0] left;
  logic [31:0] acc;
  logic [1:0]  vshift;
  logic        second;
  logic [63:0] seen;
  logic        held;

  result_t     expected_q[$];
  int          errors;
  longint      cycles;
  bit          stall_on;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic ptype_e id_type(logic [7:0] b);
    case (b)
      8'h01, 8'h17, 8'h19, 8'h24, 8'h25, 8'h28, 8'h29, 8'h2A: return T_BYTE;
      8'h13, 8'h21, 8'h22, 8'h23: return T_TWO;
      8'h02, 8'h11, 8'h18, 8'h27: return T_FOUR;
      8'h0B: return T_VAR;
      8'h03, 8'h08, 8'h12, 8'h15, 8'h1A, 8'h1C, 8'h1F: return T_STR;
      8'h26: return T_PAIR;
      8'h09, 8'h16: return T_BIN;
      default: return T_NONE;
    endcase
  endfunction

  function automatic result_t mk(kind_e k, logic [7:0] id, logic p, logic [31:0] v,
                                 logic [7:0] pb, logic pe, err_e e);
    result_t r;
    r.kind = k; r.prop_id = id; r.part_index = p; r.int_value = v;
    r.payload_byte = pb; r.part_end = pe; r.error_code = e; r.last_result = 0;
    return r;
  endfunction

  task automatic clear_parser();
    ph = P_ID; cur_id = 0; cur_type = T_BYTE; left = 0; acc = 0;
    vshift = 0; second = 0; seen = '0; held = 0;
  endtask

  task automatic finish_part();
    if (cur_type == T_PAIR && !second) begin
      second = 1;
      ph = P_LHI;
    end else begin
      ph = P_ID;
    end
  endtask

  task automatic predict_byte(logic [7:0] b, logic lst);
    result_t outs[$];
    ptype_e  t;
    if (!held) begin
      case (ph)
        P_ID: begin
          t = id_type(b);
          cur_id = b;
          if (t == T_NONE) begin
            outs.push_back(mk(KIND_ERROR, b, 0, 0, 0, 0, ERR_UNKNOWN));
            held = 1;
          end else if (b != UserProp && seen[b[5:0]]) begin
            outs.push_back(mk(KIND_ERROR, b, 0, 0, 0, 0, ERR_DUPLICATE));
            held = 1;
          end else begin
            seen[b[5:0]] = 1;
            cur_type = t; acc = 0; vshift = 0; second = 0;
            case (t)
              T_BYTE: begin left = 1; ph = P_INT; end
              T_TWO: begin left = 2; ph = P_INT; end
              T_FOUR: begin left = 4; ph = P_INT; end
              T_VAR: ph = P_VAR;
              default: ph = P_LHI;
            endcase
          end
        end
        P_INT: begin
          acc = (acc << 8) | b;
          left = left - 1;
          if (left == 0) begin
            outs.push_back(mk(KIND_INT, cur_id, 0, acc, 0, 0, ERR_NONE));
            ph = P_ID;
          end
        end
        P_VAR: begin
          acc = acc | (32'(b[6:0]) << (7 * vshift));
          if (b[7]) begin
            if (vshift == 2'd3) begin
              outs.push_back(mk(KIND_ERROR, cur_id, 0, 0, 0, 0, ERR_VARINT));
              held = 1;
            end else begin
              vshift = vshift + 1;
            end
          end else begin
            outs.push_back(mk(KIND_INT, cur_id, 0, acc, 0, 0, ERR_NONE));
            ph = P_ID;
          end
        end
        P_LHI: begin
          acc = 32'(b) << 8;
          ph = P_LLO;
        end
        P_LLO: begin
          acc = acc | b;
          outs.push_back(mk(KIND_HEADER, cur_id, second, acc, 0, 0, ERR_NONE));
          left = acc[15:0];
          if (left == 0) finish_part();
          else ph = P_DATA;
        end
        default: begin
          left = left - 1;
          outs.push_back(mk(KIND_BYTE, cur_id, second, 0, b, left == 0, ERR_NONE));
          if (left == 0) finish_part();
        end
      endcase
    end
    if (lst) begin
      outs.push_back(mk(KIND_DONE, 0, 0, 0, 0, 0,
                        (!held && ph != P_ID) ? ERR_TRUNCATED : ERR_NONE));
      clear_parser();
    end
    if (outs.size() > 0) outs[outs.size() - 1].last_result = 1;
    foreach (outs[i]) expected_q.push_back(outs[i]);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report("unexpected result, kind", res_kind, 0);
      end else begin
        e = expected_q.pop_front();
        if (res_kind != e.kind) report("kind", res_kind, e.kind);
        if (res_id != e.prop_id) report("prop_id", res_id, e.prop_id);
        if (res_part != e.part_index) report("part_index", res_part, e.part_index);
        if (res_int != e.int_value) report("int_value", res_int, e.int_value);
        if (res_pb != e.payload_byte) report("payload_byte", res_pb, e.payload_byte);
        if (res_pend != e.part_end) report("part_end", res_pend, e.part_end);
        if (res_err != e.error_code) report("error_code", res_err, e.error_code);
        if (res_last != e.last_result) report("last_result", res_last, e.last_result);
      end
    end
  end

  // Receiver stalls in phases: some stretches never stall.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (($urandom % 64) == 0) stall_on <= ~stall_on;
    out_ready <= stall_on ? ($urandom % 3 != 0) : 1'b1;
    if (cycles > 400000) begin
      $display("FAIL");
      $finish;
    end
  end

  int burst_left;

  // Sends one item; gaps are inserted between bursts.
  task automatic send_byte(logic [7:0] b, logic lst);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom % 4 == 0) ? 0 : $urandom_range(1, 6);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1;
    sec_byte <= b;
    sec_last <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(b, lst);
  endtask

  task automatic idle_sender();
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_q.size() > 0) @(posedge clk);
  endtask

  task automatic test_directed();
    // One byte, two byte, four byte and variable integers.
    send_byte(8'h01, 0); send_byte(8'hFF, 0);
    send_byte(8'h13, 0); send_byte(8'hAB, 0); send_byte(8'hCD, 0);
    send_byte(8'h02, 0); send_byte(8'hFF, 0); send_byte(8'hFF, 0);
    send_byte(8'hFF, 0); send_byte(8'hFF, 0);
    send_byte(8'h0B, 0); send_byte(8'hFF, 0); send_byte(8'hFF, 0);
    send_byte(8'hFF, 0); send_byte(8'h7F, 1);
    // User property with an empty key, then a second one cut short in its key length.
    send_byte(8'h26, 0); send_byte(8'h00, 0); send_byte(8'h00, 0);
    send_byte(8'h00, 0); send_byte(8'h01, 0); send_byte(8'h5A, 0);
    send_byte(8'h26, 0); send_byte(8'h00, 1);
    // Unknown ids and a duplicate, and a bad variable integer.
    send_byte(8'h00, 1);
    send_byte(8'hFF, 1);
    send_byte(8'h3F, 0); send_byte(8'h11, 1);
    send_byte(8'h17, 0); send_byte(8'h00, 0); send_byte(8'h17, 0);
    send_byte(8'h01, 1);
    send_byte(8'h0B, 0); send_byte(8'h80, 0); send_byte(8'h80, 0);
    send_byte(8'h80, 0); send_byte(8'h80, 0); send_byte(8'h00, 1);
    drain();
  endtask

  logic [7:0] known_ids[$] = '{8'h01, 8'h17, 8'h19, 8'h24, 8'h25, 8'h28, 8'h29, 8'h2A,
                              8'h13, 8'h21, 8'h22, 8'h23, 8'h02, 8'h11, 8'h18, 8'h27,
                              8'h0B, 8'h03, 8'h08, 8'h12, 8'h15, 8'h1A, 8'h1C, 8'h1F,
                              8'h26, 8'h09, 8'h16};

  // A mostly well-formed property with random content; the caller
  // decides where the section ends.
  task automatic build_property(ref logic [7:0] bytes[$]);
    logic [7:0] id;
    int         n;
    int         len;
    id = ($urandom % 12 == 0) ? 8'($urandom) : known_ids[$urandom % known_ids.size()];
    bytes.push_back(id);
    case (id_type(id))
      T_BYTE: n = 1;
      T_TWO: n = 2;
      T_FOUR: n = 4;
      T_VAR: begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
          bytes.push_back({(i < n - 1) ? 1'b1 : 1'($urandom % 8 == 0), 7'($urandom)});
        return;
      end
      T_NONE: return;
      default: begin
        for (int p = 0; p < ((id == UserProp) ? 2 : 1); p++) begin
          len = ($urandom % 40 == 0) ? 16'($urandom) : $urandom_range(0, 6);
          if (len > 6) begin
            // Long length field with no data behind it; the property will be cut short.
            bytes.push_back(len[15:8]); bytes.push_back(len[7:0]);
            return;
          end
          bytes.push_back(8'h00); bytes.push_back(len[7:0]);
          for (int i = 0; i < len; i++) bytes.push_back(8'($urandom));
        end
        return;
      end
    endcase
    for (int i = 0; i < n; i++) bytes.push_back(8'($urandom));
  endtask

  task automatic test_random(int target);
    int         sent;
    logic [7:0] bytes[$];
    int         cut;
    sent = 0;
    while (sent < target) begin
      bytes = {};
      repeat ($urandom_range(1, 5)) build_property(bytes);
      if ($urandom % 8 == 0) bytes.push_back(8'($urandom));
      cut = ($urandom % 6 == 0) ? $urandom_range(1, bytes.size()) : bytes.size();
      for (int i = 0; i < cut; i++) send_byte(bytes[i], i == cut - 1);
      sent += cut;
      if ($urandom % 50 == 0) drain();
    end
    drain();
  endtask

  initial begin
    errors = 0; cycles = 0; stall_on = 0; burst_left = 0;
    rst_n = 0; in_valid = 0; sec_byte = 0; sec_last = 0; out_ready = 0;
    clear_parser();
    repeat (4) @(posedge clk);
    rst_n <= 1;
    idle_sender();
    test_directed();
    test_random(1200);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/mpd_pkg.sv
hdl/mpd_front.sv
hdl/mpd_back.sv
hdl/mqtt5_property_decoder.sv
test/tb.sv
